[design/pli_pkg.sv]
`default_nettype none
package pli_pkg;

  localparam int MaxPoints = 16;
  localparam int NumPointsW = 5;
  localparam int DataW = 32;
  localparam int FifoDepth = 2;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_LOW    = 2'd0,
    REG_HIGH   = 2'd1,
    REG_INTERP = 2'd2,
    REG_NONE   = 2'd3
  } region_t;

  typedef struct packed {
    logic                    is_eval;
    logic [7:0]              idx;
    logic signed [DataW-1:0] xv;
    logic signed [DataW-1:0] yv;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RDLAST,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

[design/piecewise_linear_interp.sv]
`default_nettype none
// Piecewise linear interpolation over up to MAX_POINTS (x, y) breakpoints in
// signed Q16.16. A cmd=0 beat writes one breakpoint and gives no result; a
// cmd=1 beat evaluates x_value and gives one result beat. Writes are taken
// from the head of the two-entry input queue while the back end is idle. An
// evaluate that is clamped low or high skips the scan; otherwise the
// breakpoint memory is scanned one entry per cycle, and an x_value inside a
// segment is interpolated (a multiply and a bit-serial 66-step divide). A
// stalled result beat holds the back end.
module piecewise_linear_interp #(
  parameter int MAX_POINTS = pli_pkg::MaxPoints
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [4:0]              cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_cmd,
  input  wire logic [3:0]              in_point_index,
  input  wire logic signed [31:0]      in_x_value,
  input  wire logic signed [31:0]      in_y_value,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [31:0]           out_y_out,
  output logic [1:0]                   out_region,
  output logic                         out_saturated
);

  logic [pli_pkg::NumPointsW-1:0] num_points_r;
  logic q_valid, q_pop;
  pli_pkg::job_t q_job;

  always_ff @(posedge clk) begin
    if (!rst_n) num_points_r <= pli_pkg::NumPointsW'(1);
    else if (cfg_we) num_points_r <= cfg_wdata;
  end

  pli_front #(.MAX_POINTS(MAX_POINTS), .IDX_W(4)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_point_index,
    .in_x_value, .in_y_value, .q_valid, .q_pop, .q_job
  );

  pli_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk, .rst_n, .num_points(num_points_r), .q_valid, .q_pop, .q_job,
    .out_valid, .out_stall, .out_y_out, .out_region, .out_saturated
  );

endmodule
`default_nettype wire

[design/pli_front.sv]
`default_nettype none
module pli_front #(
  parameter int MAX_POINTS = pli_pkg::MaxPoints,
  parameter int IDX_W = (MAX_POINTS > 16) ? $clog2(MAX_POINTS) : 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_cmd,
  input  wire logic [IDX_W-1:0]             in_point_index,
  input  wire logic signed [pli_pkg::DataW-1:0] in_x_value,
  input  wire logic signed [pli_pkg::DataW-1:0] in_y_value,
  output logic                              q_valid,
  input  wire logic                         q_pop,
  output pli_pkg::job_t                     q_job
);

  pli_pkg::job_t fifo_r [pli_pkg::FifoDepth];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push;
  pli_pkg::job_t job;

  always_comb begin
    job.is_eval = (pli_pkg::cmd_t'(in_cmd) == pli_pkg::CMD_EVAL);
    job.idx = 8'(in_point_index);
    job.xv = in_x_value;
    job.yv = in_y_value;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall &&
                (job.is_eval || (32'(in_point_index) < MAX_POINTS));
  assign q_valid = (cnt_r != 2'd0);
  assign q_job = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

[design/pli_back.sv]
`default_nettype none
module pli_back #(
  parameter int MAX_POINTS = pli_pkg::MaxPoints,
  parameter int AW = $clog2(MAX_POINTS)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [pli_pkg::NumPointsW-1:0] num_points,
  input  wire logic                         q_valid,
  output logic                              q_pop,
  input  wire pli_pkg::job_t                q_job,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [pli_pkg::DataW-1:0]  out_y_out,
  output logic [1:0]                        out_region,
  output logic                              out_saturated
);

  localparam int W = pli_pkg::DataW;
  localparam logic signed [W+1:0] SumMax = 34'sh0_7FFF_FFFF;
  localparam logic signed [W+1:0] SumMin = -34'sh0_8000_0000;

  logic [2*W-1:0] mem_r [MAX_POINTS];
  logic [2*W-1:0] rd_r;
  logic [AW-1:0] raddr;
  logic rd_en;

  pli_pkg::state_t st_r, st_nxt;
  logic [AW:0] last_r, i_r;
  logic signed [W-1:0] q_r, x0_r, y0_r, xprev_r, yprev_r;
  logic signed [W-1:0] sx0_r, sx1_r, sy0_r, sy1_r;
  logic found_r;
  logic [W:0] mag_r, span_r;
  logic neg_r;
  logic [2*W+1:0] prod_r;
  logic [W:0] rem_r;
  logic [6:0] dcnt_r;
  logic signed [W-1:0] y_r;
  logic [1:0] reg_r;
  logic sat_r, ovalid_r;

  logic signed [W-1:0] cx, cy;
  logic [AW:0] n_eff;
  logic [W+1:0] trial;
  logic [W:0] rem_sh;
  logic qsat;
  logic signed [W+1:0] qs, sum;

  assign cx = $signed(rd_r[2*W-1:W]);
  assign cy = $signed(rd_r[W-1:0]);

  always_comb begin
    if (num_points == '0) n_eff = (AW+1)'(1);
    else if (32'(num_points) > MAX_POINTS) n_eff = (AW+1)'(MAX_POINTS);
    else n_eff = (AW+1)'(num_points);
  end

  always_ff @(posedge clk) begin
    if (q_valid && !q_job.is_eval && st_r == pli_pkg::ST_IDLE)
      mem_r[q_job.idx[AW-1:0]] <= {q_job.xv, q_job.yv};
    if (rd_en) rd_r <= mem_r[raddr];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      pli_pkg::ST_IDLE:   if (q_valid && q_job.is_eval) st_nxt = pli_pkg::ST_RD0;
      pli_pkg::ST_RD0:    st_nxt = pli_pkg::ST_RDLAST;
      pli_pkg::ST_RDLAST: begin
        if (q_r <= x0_r || q_r > cx) st_nxt = pli_pkg::ST_OUT;
        else st_nxt = pli_pkg::ST_SCAN;
      end
      pli_pkg::ST_SCAN: begin
        if (i_r == last_r + 1'b1) begin
          if (found_r) st_nxt = pli_pkg::ST_MUL;
          else st_nxt = pli_pkg::ST_OUT;
        end
      end
      pli_pkg::ST_MUL:    st_nxt = pli_pkg::ST_DIV;
      pli_pkg::ST_DIV:    if (dcnt_r == '0) st_nxt = pli_pkg::ST_FIN;
      pli_pkg::ST_FIN:    st_nxt = pli_pkg::ST_OUT;
      pli_pkg::ST_OUT:    if (!ovalid_r || !out_stall) st_nxt = pli_pkg::ST_IDLE;
      default:            st_nxt = pli_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (st_r == pli_pkg::ST_IDLE) && q_valid;
    rd_en = 1'b1;
    raddr = '0;
    unique case (st_r)
      pli_pkg::ST_IDLE:   raddr = '0;
      pli_pkg::ST_RD0:    raddr = AW'(n_eff - 1'b1);
      pli_pkg::ST_RDLAST: raddr = AW'(1);
      pli_pkg::ST_SCAN:   raddr = AW'(i_r + 1'b1);
      default:            rd_en = 1'b0;
    endcase
  end

  assign rem_sh = {rem_r[W-1:0], prod_r[2*W+1]};
  assign trial = {1'b0, rem_sh} - {1'b0, span_r};
  assign qsat = |prod_r[2*W+1:W+1] ||
                (!neg_r && prod_r[W:0] > (W+1)'(32'h7FFFFFFF)) ||
                (neg_r && prod_r[W:0] > (W+1)'(33'h080000000));
  assign qs = qsat ? (neg_r ? SumMin : SumMax) :
              (neg_r ? -$signed({1'b0, prod_r[W:0]}) : $signed({1'b0, prod_r[W:0]}));
  assign sum = qs + (W+2)'(y0_r);

  always_ff @(posedge clk) begin
    unique case (st_r)
      pli_pkg::ST_IDLE: begin
        q_r <= q_job.xv;
        last_r <= n_eff - 1'b1;
        found_r <= 1'b0;
        sat_r <= 1'b0;
      end
      pli_pkg::ST_RD0: begin
        x0_r <= cx;
        y0_r <= cy;
        xprev_r <= cx;
        yprev_r <= cy;
        i_r <= (AW+1)'(1);
      end
      pli_pkg::ST_RDLAST: begin
        y_r <= y0_r;
        reg_r <= pli_pkg::REG_LOW;
        if (q_r > x0_r) begin
          y_r <= cy;
          reg_r <= (q_r > cx) ? pli_pkg::REG_HIGH : pli_pkg::REG_NONE;
        end
      end
      pli_pkg::ST_SCAN: begin
        if (i_r <= last_r) begin
          if (q_r > xprev_r && q_r <= cx) begin
            found_r <= 1'b1;
            sx0_r <= xprev_r;
            sx1_r <= cx;
            sy0_r <= yprev_r;
            sy1_r <= cy;
          end
          xprev_r <= cx;
          yprev_r <= cy;
          i_r <= i_r + 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
          if (reg_r == pli_pkg::REG_NONE && !found_r) y_r <= '0;
        end
        if (i_r == last_r + 1'b1 && reg_r == pli_pkg::REG_NONE && !found_r) y_r <= '0;
      end
      pli_pkg::ST_MUL: begin
        begin
          logic signed [W:0] dy;
          dy = (W+1)'(sy1_r) - (W+1)'(sy0_r);
          neg_r <= dy[W];
          mag_r <= dy[W] ? (W+1)'(-dy) : (W+1)'(dy);
          span_r <= (W+1)'(sx1_r) - (W+1)'(sx0_r);
        end
        y0_r <= sy0_r;
        reg_r <= pli_pkg::REG_INTERP;
        rem_r <= '0;
        dcnt_r <= 7'(2*W+3);
        prod_r <= '0;
      end
      pli_pkg::ST_DIV: begin
        if (dcnt_r == 7'(2*W+3)) begin
          prod_r <= (2*W+2)'(mag_r) * (2*W+2)'((W+1)'(q_r) - (W+1)'(sx0_r));
          dcnt_r <= dcnt_r - 1'b1;
        end else if (dcnt_r != '0) begin
          dcnt_r <= dcnt_r - 1'b1;
          if (!trial[W+1]) begin
            rem_r <= trial[W:0];
            prod_r <= {prod_r[2*W:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            prod_r <= {prod_r[2*W:0], 1'b0};
          end
        end
      end
      pli_pkg::ST_FIN: begin
        if (span_r == '0) begin
          y_r <= y0_r;
        end else if (sum > SumMax) begin
          sat_r <= 1'b1;
          y_r <= {1'b0, {(W-1){1'b1}}};
        end else if (sum < SumMin) begin
          sat_r <= 1'b1;
          y_r <= {1'b1, {(W-1){1'b0}}};
        end else begin
          sat_r <= qsat;
          y_r <= sum[W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pli_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      if (st_r == pli_pkg::ST_OUT && (!ovalid_r || !out_stall)) begin
        ovalid_r <= 1'b1;
        out_y_out <= y_r;
        out_region <= reg_r;
        out_saturated <= sat_r;
      end
    end
  end

  assign out_valid = ovalid_r;

endmodule
`default_nettype wire
